// File: hw/rtl/kcurve_pkg.sv
// Shared types and constants for the keyframe curve evaluator.
`timescale 1ns / 1ps
`default_nettype none
package kcurve_pkg;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_DROP  = 2'd2;

  localparam int FRAME_W = 24;
  localparam int VALUE_W = 32;
  localparam int EASE_W  = 16;
  localparam int ACC_W   = 64;
  localparam int FRAC_W  = 25;
  localparam int DIVN_W  = FRAME_W + 16;
  localparam int DCNT_W  = 6;
  localparam int MCNT_W  = 5;
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIVN_W - 1);
  localparam logic [MCNT_W-1:0] MUL_LAST = MCNT_W'(FRAC_W - 1);

  localparam logic [2:0] LERP_P0    = 3'd0;
  localparam logic [2:0] LERP_P1    = 3'd1;
  localparam logic [2:0] LERP_P2    = 3'd2;
  localparam logic [2:0] LERP_M0    = 3'd3;
  localparam logic [2:0] LERP_M1    = 3'd4;
  localparam logic [2:0] LERP_T     = 3'd5;
  localparam logic [2:0] LERP_VALUE = 3'd6;

  localparam logic signed [ACC_W-1:0] Q16_ONE = 64'sd65536;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [VALUE_W-1:0] value;
    logic [EASE_W-1:0]  ein;
    logic [EASE_W-1:0]  eout;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_READ, S_CHECK, S_DIV, S_LERP, S_MUL, S_WB, S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_rd;
    logic advance;
    logic take_cur;
    logic div_start;
    logic div_step;
    logic mul_start;
    logic mul_step;
    logic mul_wb;
  } cmd_t;

  typedef struct packed {
    logic go_scan;
    logic hit;
    logic first;
    logic last;
    logic degen;
    logic div_last;
    logic mul_last;
    logic lerp_last;
  } stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/kcurve_ctrl.sv
// Controller state machine for the keyframe curve evaluator.
`timescale 1ns / 1ps
`default_nettype none
module kcurve_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire kcurve_pkg::stat_t st,
  output kcurve_pkg::cmd_t     cmd,
  output logic                 busy,
  output logic                 done
);

  kcurve_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kcurve_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != kcurve_pkg::S_IDLE);
    done = (state == kcurve_pkg::S_OUT);
    case (state)
      kcurve_pkg::S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = kcurve_pkg::S_DISPATCH;
        end
      end
      kcurve_pkg::S_DISPATCH: begin
        state_next = st.go_scan ? kcurve_pkg::S_READ : kcurve_pkg::S_OUT;
      end
      kcurve_pkg::S_READ: begin
        cmd.scan_rd = 1'b1;
        state_next = kcurve_pkg::S_CHECK;
      end
      kcurve_pkg::S_CHECK: begin
        if (st.hit) begin
          if (st.first || st.degen) begin
            cmd.take_cur = 1'b1;
            state_next = kcurve_pkg::S_OUT;
          end else begin
            cmd.div_start = 1'b1;
            state_next = kcurve_pkg::S_DIV;
          end
        end else if (st.last) begin
          cmd.take_cur = 1'b1;
          state_next = kcurve_pkg::S_OUT;
        end else begin
          cmd.advance = 1'b1;
          state_next = kcurve_pkg::S_READ;
        end
      end
      kcurve_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = kcurve_pkg::S_LERP;
        end
      end
      kcurve_pkg::S_LERP: begin
        cmd.mul_start = 1'b1;
        state_next = kcurve_pkg::S_MUL;
      end
      kcurve_pkg::S_MUL: begin
        cmd.mul_step = 1'b1;
        if (st.mul_last) begin
          state_next = kcurve_pkg::S_WB;
        end
      end
      kcurve_pkg::S_WB: begin
        cmd.mul_wb = 1'b1;
        state_next = st.lerp_last ? kcurve_pkg::S_OUT : kcurve_pkg::S_LERP;
      end
      kcurve_pkg::S_OUT: begin
        state_next = kcurve_pkg::S_IDLE;
      end
      default: begin
        state_next = kcurve_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/kcurve_datapath.sv
// Datapath: keyframe memory, scan, serial divider and serial lerp unit.
`timescale 1ns / 1ps
`default_nettype none
module kcurve_datapath #(
  parameter int MAX_KEYFRAMES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire kcurve_pkg::cmd_t   cmd,
  output kcurve_pkg::stat_t       st,
  input  wire logic [1:0]         mode,
  input  wire logic [23:0]        key_frame,
  input  wire logic signed [31:0] key_value,
  input  wire logic [15:0]        ease_in,
  input  wire logic [15:0]        ease_out,
  input  wire logic [23:0]        query_frame,
  output logic signed [31:0]      curve_value,
  output logic [1:0]              status
);

  localparam int AW = $clog2(MAX_KEYFRAMES);
  localparam int CW = $clog2(MAX_KEYFRAMES + 1);
  localparam int FW = kcurve_pkg::FRAME_W;
  localparam int LW = kcurve_pkg::ACC_W;
  localparam int QW = kcurve_pkg::FRAC_W;
  localparam int NW = kcurve_pkg::DIVN_W;

  kcurve_pkg::entry_t mem [MAX_KEYFRAMES];
  kcurve_pkg::entry_t rdata;
  kcurve_pkg::entry_t prev;

  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [1:0]    mode_r;
  logic [FW-1:0] qf;
  logic          full;

  logic [NW-1:0] dnum;
  logic [FW-1:0] drem;
  logic [FW-1:0] dden;
  logic [kcurve_pkg::DCNT_W-1:0] dcnt;
  logic [FW:0]   dtrial;
  logic          dfit;

  logic [QW-1:0] frac;
  logic [QW-1:0] tcl;
  logic signed [LW-1:0] p0, p1, p2, m0, m1;
  logic [2:0]    lstep;
  logic signed [LW-1:0] opa, opb_sel, opa_sel;
  logic [QW-1:0] fac_sel;
  logic signed [LW-1:0] acc, mcand;
  logic [QW-1:0] mplier;
  logic [kcurve_pkg::MCNT_W-1:0] mcnt;
  logic signed [LW-1:0] tq, lres;

  assign full = (count == CW'(MAX_KEYFRAMES));

  always_ff @(posedge clk) begin
    if (cmd.accept && mode == kcurve_pkg::MODE_APPEND && !full) begin
      mem[count[AW-1:0]] <= {key_frame, key_value, ease_in, ease_out};
    end
    if (cmd.scan_rd) begin
      rdata <= mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.accept) begin
      if (mode == kcurve_pkg::MODE_CLEAR) begin
        count <= '0;
      end else if (mode == kcurve_pkg::MODE_APPEND && !full) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= mode;
      qf <= query_frame;
      idx <= '0;
      curve_value <= '0;
      if (mode == kcurve_pkg::MODE_APPEND && full) begin
        status <= kcurve_pkg::ST_DROP;
      end else if (mode == kcurve_pkg::MODE_QUERY && count == '0) begin
        status <= kcurve_pkg::ST_EMPTY;
      end else begin
        status <= kcurve_pkg::ST_OK;
      end
    end
    if (cmd.advance) begin
      idx <= idx + 1'b1;
      prev <= rdata;
    end
    if (cmd.take_cur) begin
      curve_value <= $signed(rdata.value);
    end
    if (cmd.mul_wb && lstep == kcurve_pkg::LERP_VALUE) begin
      curve_value <= lres[31:0];
    end
  end

  assign st.go_scan   = (mode_r == kcurve_pkg::MODE_QUERY) && (count != '0);
  assign st.hit       = rdata.frame >= {qf[FW-1:8], 8'd0};
  assign st.first     = (idx == '0);
  assign st.last      = (idx == count - 1'b1);
  assign st.degen     = rdata.frame <= prev.frame;
  assign st.div_last  = (dcnt == kcurve_pkg::DIV_LAST);
  assign st.mul_last  = (mcnt == kcurve_pkg::MUL_LAST);
  assign st.lerp_last = (lstep == kcurve_pkg::LERP_VALUE);

  // restoring divider, one quotient bit per cycle
  assign dtrial = {drem, dnum[NW-1]};
  assign dfit   = dtrial >= {1'b0, dden};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dnum <= {qf - prev.frame, 16'd0};
      dden <= rdata.frame - prev.frame;
      drem <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      drem <= dfit ? FW'(dtrial - {1'b0, dden}) : dtrial[FW-1:0];
      dnum <= {dnum[NW-2:0], dfit};
      dcnt <= dcnt + 1'b1;
    end
  end

  assign frac = dnum[QW-1:0];

  always_comb begin
    opa_sel = '0;
    opb_sel = '0;
    fac_sel = frac;
    case (lstep)
      kcurve_pkg::LERP_P0: begin
        opa_sel = '0;
        opb_sel = LW'(prev.ein);
      end
      kcurve_pkg::LERP_P1: begin
        opa_sel = LW'(prev.ein);
        opb_sel = LW'(prev.eout);
      end
      kcurve_pkg::LERP_P2: begin
        opa_sel = LW'(prev.eout);
        opb_sel = kcurve_pkg::Q16_ONE;
      end
      kcurve_pkg::LERP_M0: begin
        opa_sel = p0;
        opb_sel = p1;
      end
      kcurve_pkg::LERP_M1: begin
        opa_sel = p1;
        opb_sel = p2;
      end
      kcurve_pkg::LERP_T: begin
        opa_sel = m0;
        opb_sel = m1;
      end
      kcurve_pkg::LERP_VALUE: begin
        opa_sel = LW'($signed(prev.value));
        opb_sel = LW'($signed(rdata.value));
        fac_sel = tcl;
      end
      default: begin
        opa_sel = '0;
        opb_sel = '0;
      end
    endcase
  end

  // shift-add multiplier, quotient truncated toward zero
  assign tq   = (acc + (acc[LW-1] ? LW'(65535) : LW'(0))) >>> 16;
  assign lres = opa + tq;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      lstep <= kcurve_pkg::LERP_P0;
    end
    if (cmd.mul_start) begin
      opa <= opa_sel;
      mcand <= opb_sel - opa_sel;
      mplier <= fac_sel;
      acc <= '0;
      mcnt <= '0;
    end else if (cmd.mul_step) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand <= mcand <<< 1;
      mplier <= mplier >> 1;
      mcnt <= mcnt + 1'b1;
    end
    if (cmd.mul_wb) begin
      lstep <= lstep + 1'b1;
      case (lstep)
        kcurve_pkg::LERP_P0: p0 <= lres;
        kcurve_pkg::LERP_P1: p1 <= lres;
        kcurve_pkg::LERP_P2: p2 <= lres;
        kcurve_pkg::LERP_M0: m0 <= lres;
        kcurve_pkg::LERP_M1: m1 <= lres;
        kcurve_pkg::LERP_T: begin
          if (lres < 0) begin
            tcl <= '0;
          end else if (lres > kcurve_pkg::Q16_ONE) begin
            tcl <= QW'(kcurve_pkg::Q16_ONE);
          end else begin
            tcl <= lres[QW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/keyframe_curve_evaluator.sv
// Top level of the keyframe curve evaluator.
//
// channel  | handshake          | ports
// ---------+--------------------+------------------------------------------------
// item in  | start && !busy     | mode key_frame key_value ease_in ease_out query_frame
// result   | done, one cycle    | curve_value status
//
// Clear, append and mode three pass from accept through the dispatch state to done.
// A query scans one keyframe at a time through the read and check states, then
// runs the serial divider and seven passes through the shared serial multiplier,
// unless a keyframe's own value is taken. busy stays high until done has shown.
// rst is synchronous and empties the table; done cannot be held off.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_curve_evaluator #(
  parameter int MAX_KEYFRAMES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         mode,
  input  wire logic [23:0]        key_frame,
  input  wire logic signed [31:0] key_value,
  input  wire logic [15:0]        ease_in,
  input  wire logic [15:0]        ease_out,
  input  wire logic [23:0]        query_frame,
  output logic                    done,
  output logic signed [31:0]      curve_value,
  output logic [1:0]              status
);

  kcurve_pkg::cmd_t  cmd;
  kcurve_pkg::stat_t st;

  kcurve_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  kcurve_datapath #(
    .MAX_KEYFRAMES (MAX_KEYFRAMES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .mode        (mode),
    .key_frame   (key_frame),
    .key_value   (key_value),
    .ease_in     (ease_in),
    .ease_out    (ease_out),
    .query_frame (query_frame),
    .curve_value (curve_value),
    .status      (status)
  );

endmodule
`default_nettype wire

// File: hw/rtl/kcurve_checker.sv
// Port-level checks for the keyframe curve evaluator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module kcurve_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [31:0] curve_value,
  input wire logic [1:0]  status
);

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("item accepted but not busy");

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result shown while idle");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != kcurve_pkg::ST_OK) |-> curve_value == '0)
    else $error("nonzero value with error status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == kcurve_pkg::ST_OK || status == kcurve_pkg::ST_EMPTY ||
              status == kcurve_pkg::ST_DROP)) else $error("bad status code");

endmodule

bind keyframe_curve_evaluator kcurve_checker u_kcurve_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .curve_value (curve_value),
  .status      (status)
);
`default_nettype wire
